@@ rtl/core/lisr_pkg.sv @@
// Shared types and constants for the linear interpolation speed resampler.
// No dependencies.
package lisr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W = 14;
  localparam int SPEED_W = 20;
  localparam int FRAC_W = 16;
  localparam int BUFFER_DEPTH_DEF = 1024;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 20'h10000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        operation;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_sample;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [INDEX_W-1:0]         index;
    logic                       done_res;
  } res_t;

  // control that rides alongside a pull through the pipeline
  typedef struct packed {
    logic               done;
    logic [INDEX_W-1:0] index;
  } tag_t;

endpackage

@@ rtl/core/lisr_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module lisr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/core/lisr_interp.sv @@
// Interpolation datapath: registered (next - prev) * frac, then prev + product >>> 16.
// Depends on lisr_pkg.
module lisr_interp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  lisr_pkg::tag_t                       tag_i,
  input  logic signed [lisr_pkg::SAMPLE_W-1:0] prev_i,
  input  logic signed [lisr_pkg::SAMPLE_W-1:0] next_i,
  input  logic [lisr_pkg::FRAC_W-1:0]          frac_i,
  output logic                                 res_strobe_o,
  output lisr_pkg::res_t                       res_o
);

  localparam int DIFF_W = lisr_pkg::SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + lisr_pkg::FRAC_W;

  logic signed [DIFF_W-1:0]          diff;
  logic signed [DIFF_W+lisr_pkg::FRAC_W:0] prod_full;
  logic signed [PROD_W-1:0]          prod_d, prod_q;
  logic signed [lisr_pkg::SAMPLE_W-1:0] prev_q;
  lisr_pkg::tag_t                    tag_q;
  logic                              valid_q;
  logic signed [DIFF_W-1:0]          sum;
  lisr_pkg::res_t                    res_d, res_q;
  logic                              strobe_q;

  assign diff      = DIFF_W'(next_i) - DIFF_W'(prev_i);
  assign prod_full = diff * $signed({1'b0, frac_i});
  assign prod_d    = PROD_W'(prod_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      valid_q  <= valid_i;
      strobe_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    prev_q <= prev_i;
    tag_q  <= tag_i;
    res_q  <= res_d;
  end

  assign sum = DIFF_W'(prev_q) + $signed(prod_q[PROD_W-1:lisr_pkg::FRAC_W]);

  always_comb begin
    res_d.index    = tag_q.index;
    res_d.done_res = tag_q.done;
    if (tag_q.done) begin
      res_d.sample_out = '0;
    end else begin
      res_d.sample_out = sum[lisr_pkg::SAMPLE_W-1:0];
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

@@ rtl/core/linear_interp_speed_resampler.sv @@
// Linear interpolation speed resampler: sample buffer load and Q.16 position playback.
// Pull results pass stage 1, product and result registers; strobed for one cycle.
// Throughput: one transaction per cycle; busy is never raised, loads produce no result.
// The sample RAM gives one write and two reads a cycle, so loads and pulls may interleave.
// Reset clears count, position, output counter and armed, sets speed to 1.0; RAM undefined.
// Depends on lisr_pkg, lisr_ram, lisr_interp.
module linear_interp_speed_resampler #(
  parameter int BUFFER_DEPTH = lisr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  lisr_pkg::req_t               req_i,
  output logic                         res_strobe_o,
  output lisr_pkg::res_t               res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lisr_pkg::SPEED_W-1:0] cfg_data_i
);

  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int POS_W = CNT_W + lisr_pkg::FRAC_W;
  localparam int SUM_W = ((POS_W > lisr_pkg::SPEED_W) ? POS_W : lisr_pkg::SPEED_W) + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

  logic [lisr_pkg::SPEED_W-1:0] speed_q;
  logic [CNT_W-1:0]             cnt_q, cnt_d, cnt_eff;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [lisr_pkg::INDEX_W-1:0] ocnt_q, ocnt_d;
  logic                         armed_q, armed_d;

  logic                         accept, is_load, is_pull;
  logic [CNT_W-1:0]             ip;
  logic [SUM_W-1:0]             pos_sum, cnt_pos;
  logic                         pull_done;
  logic                         ram_we;
  logic [AW-1:0]                addr_a, addr_b;
  logic [lisr_pkg::SAMPLE_W-1:0] rd_a, rd_b;

  logic                         s1_valid_q;
  lisr_pkg::tag_t               s1_tag_d, s1_tag_q;
  logic [lisr_pkg::FRAC_W-1:0]  s1_frac_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign is_load     = accept && (req_i.operation == lisr_pkg::OP_LOAD);
  assign is_pull     = accept && (req_i.operation == lisr_pkg::OP_PULL);

  assign ip      = pos_q[POS_W-1:lisr_pkg::FRAC_W];
  assign pos_sum = SUM_W'(pos_q) + SUM_W'(speed_q);
  assign cnt_pos = SUM_W'({cnt_q, {lisr_pkg::FRAC_W{1'b0}}});

  assign pull_done = !armed_q || (cnt_q == '0) || (ip >= cnt_q - CNT_W'(1)) ||
                     (pos_sum > cnt_pos);

  assign cnt_eff = armed_q ? '0 : cnt_q;
  assign ram_we  = is_load && (cnt_eff < DEPTH_CNT);
  assign addr_a  = ip[AW-1:0];
  assign addr_b  = ip[AW-1:0] + AW'(1);

  always_comb begin
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ocnt_d  = ocnt_q;
    armed_d = armed_q;
    if (is_load) begin
      cnt_d   = ram_we ? cnt_eff + CNT_W'(1) : cnt_eff;
      armed_d = 1'b0;
      if (req_i.last_sample) begin
        armed_d = 1'b1;
        pos_d   = '0;
        ocnt_d  = '0;
      end
    end else if (is_pull && !pull_done) begin
      pos_d  = pos_sum[POS_W-1:0];
      ocnt_d = ocnt_q + lisr_pkg::INDEX_W'(1);
    end
  end

  always_comb begin
    s1_tag_d.done  = pull_done;
    s1_tag_d.index = armed_q ? ocnt_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q    <= lisr_pkg::SPEED_RESET;
      cnt_q      <= '0;
      pos_q      <= '0;
      ocnt_q     <= '0;
      armed_q    <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        speed_q <= cfg_data_i;
      end
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      ocnt_q     <= ocnt_d;
      armed_q    <= armed_d;
      s1_valid_q <= is_pull;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q  <= s1_tag_d;
    s1_frac_q <= pos_q[lisr_pkg::FRAC_W-1:0];
  end

  lisr_ram #(
    .WIDTH(lisr_pkg::SAMPLE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (cnt_eff[AW-1:0]),
    .wdata_i   (req_i.sample_in),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  lisr_interp u_interp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid_q),
    .tag_i        (s1_tag_q),
    .prev_i       ($signed(rd_a)),
    .next_i       ($signed(rd_b)),
    .frac_i       (s1_frac_q),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  a_pull_gets_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.operation == lisr_pkg::OP_PULL) |-> ##3 res_strobe_o)
    else $error("pull transaction without result");

  a_result_from_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(is_pull, 3))
    else $error("result without pull transaction");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("sample count beyond buffer depth");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.done_res) |-> (res_o.sample_out == '0))
    else $error("done result carries a sample");

endmodule

@@ bench/linear_interp_speed_resampler_tb.sv @@
// Self-checking testbench for linear_interp_speed_resampler: sample loads, pulls, speed writes.
// A scoreboard class predicts each pull answer and compares it with the strobed result.
// Depends on lisr_pkg and the resampler RTL.
module linear_interp_speed_resampler_tb;

  localparam int N_ITEMS   = 1650;
  localparam int IDLE_STOP = 1400;

  class resampler_scoreboard;
    logic [lisr_pkg::SPEED_W-1:0]         speed = lisr_pkg::SPEED_RESET;
    logic signed [lisr_pkg::SAMPLE_W-1:0] samples [lisr_pkg::BUFFER_DEPTH_DEF];
    int unsigned                          count = 0;
    longint unsigned                      pos = 0;
    logic [lisr_pkg::INDEX_W-1:0]         out_cnt = '0;
    bit                                   armed = 0;
    lisr_pkg::res_t                       pending[$];
    int errors = 0;
    int loads = 0;
    int pulls = 0;
    int outputs = 0;
    int ends = 0;
    int speed_writes = 0;

    function void note_request(lisr_pkg::req_t r);
      lisr_pkg::res_t  e;
      longint unsigned ip;
      longint          a;
      longint          b;
      longint          prod;
      longint          val;
      bit              over;
      if (r.operation == lisr_pkg::OP_LOAD) begin
        loads++;
        if (armed) begin
          armed = 0;
          count = 0;
        end
        if (count < lisr_pkg::BUFFER_DEPTH_DEF) begin
          samples[count] = r.sample_in;
          count++;
        end
        if (r.last_sample) begin
          armed = 1;
          pos = 0;
          out_cnt = '0;
        end
        return;
      end
      pulls++;
      e.sample_out = '0;
      e.index = '0;
      e.done_res = 1'b1;
      if (armed) begin
        e.index = out_cnt;
        over = (count == 0) || (pos >= (longint'(count - 1) << lisr_pkg::FRAC_W)) ||
               (pos + speed > (longint'(count) << lisr_pkg::FRAC_W));
        if (!over) begin
          ip = pos >> lisr_pkg::FRAC_W;
          a = longint'(samples[ip]);
          b = longint'(samples[ip + 1]);
          prod = (b - a) * longint'(pos[lisr_pkg::FRAC_W-1:0]);
          val = a + (prod >>> lisr_pkg::FRAC_W);
          e.sample_out = val[lisr_pkg::SAMPLE_W-1:0];
          e.done_res = 1'b0;
          out_cnt = out_cnt + 1'b1;
          pos = pos + speed;
        end
      end
      if (e.done_res) ends++;
      else outputs++;
      pending.push_back(e);
    endfunction

    function void check_result(lisr_pkg::res_t r);
      lisr_pkg::res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result sample_out=%0d index=%0d done=%0b",
                 $time, r.sample_out, r.index, r.done_res);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.sample_out !== e.sample_out) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.sample_out, r.sample_out);
        errors++;
      end
      if (r.index !== e.index) begin
        $display("%0t: index expected %0d actual %0d", $time, e.index, r.index);
        errors++;
      end
      if (r.done_res !== e.done_res) begin
        $display("%0t: done_res expected %0b actual %0b", $time, e.done_res, r.done_res);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  lisr_pkg::req_t               req_i;
  logic                         res_strobe_o;
  lisr_pkg::res_t               res_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [lisr_pkg::SPEED_W-1:0] cfg_data_i;

  resampler_scoreboard          sb = new;
  bit                           idle_on = 0;
  int                           sent_items = 0;
  logic [lisr_pkg::SPEED_W-1:0] cur_speed = lisr_pkg::SPEED_RESET;

  linear_interp_speed_resampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe_o) sb.check_result(res_o);
      if (start && !busy) sb.note_request(req_i);
      if (cfg_valid_i && cfg_ready_o) begin
        sb.speed = cfg_data_i;
        sb.speed_writes++;
      end
    end
  end

  task automatic send_item(input lisr_pkg::req_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sent_items++;
  endtask

  task automatic load_sample(input logic [lisr_pkg::SAMPLE_W-1:0] v, input bit last);
    lisr_pkg::req_t r;
    r.operation = lisr_pkg::OP_LOAD;
    r.sample_in = v;
    r.last_sample = last;
    send_item(r);
  endtask

  task automatic pull_once();
    lisr_pkg::req_t r;
    r.operation = lisr_pkg::OP_PULL;
    r.sample_in = lisr_pkg::SAMPLE_W'($urandom);
    r.last_sample = ($urandom_range(0, 1) != 0);
    send_item(r);
  endtask

  // drain: no transaction in flight, result pipeline empty
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_speed(input logic [lisr_pkg::SPEED_W-1:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_speed = v;
  endtask

  function automatic logic [lisr_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return lisr_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [lisr_pkg::SPEED_W-1:0] pick_speed();
    logic [lisr_pkg::SPEED_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = 20'd4096;
      1: s = 20'd524288;
      2: s = lisr_pkg::SPEED_RESET;
      3: s = lisr_pkg::SPEED_W'($urandom);
      default: s = lisr_pkg::SPEED_W'($urandom_range(4096, 524288));
    endcase
    if (s == 0) s = 20'd4096;
    return s;
  endfunction

  // outputs a buffer of len samples gives before the end test trips
  function automatic int run_length(input int len, input logic [lisr_pkg::SPEED_W-1:0] spd);
    longint unsigned p;
    longint unsigned lim_lo;
    longint unsigned lim_hi;
    int              n;
    p = 0;
    n = 0;
    if (len < 2) return 0;
    if (spd == 0) return 3;
    lim_lo = longint'(len - 1) << lisr_pkg::FRAC_W;
    lim_hi = longint'(len) << lisr_pkg::FRAC_W;
    while (p < lim_lo && p + spd <= lim_hi) begin
      n++;
      p += spd;
    end
    return n;
  endfunction

  initial begin
    int len;
    int n;
    int w;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pull before any buffer is armed
    pull_once();
    load_sample(16'h7fff, 1'b0);
    load_sample(16'h8000, 1'b1);
    repeat (2) pull_once();

    // half speed across full-scale steps, floor rounding on negative slopes
    write_speed(20'd32768);
    load_sample(16'h7fff, 1'b0);
    load_sample(16'h8000, 1'b0);
    load_sample(16'h7fff, 1'b0);
    load_sample(16'hffff, 1'b1);
    repeat (7) pull_once();

    // zero speed repeats the first sample
    write_speed(20'd0);
    load_sample(16'h8000, 1'b0);
    load_sample(16'h7fff, 1'b1);
    repeat (3) pull_once();

    // largest step: ends on the position-plus-speed test
    write_speed(20'hfffff);
    load_sample(16'h1234, 1'b0);
    load_sample(16'hedcb, 1'b0);
    load_sample(16'h0001, 1'b1);
    pull_once();
    pull_once();
    load_sample(16'h4000, 1'b1);
    pull_once();

    // full buffer with dropped loads, played back at speed 8.0
    write_speed(20'd524288);
    for (int i = 0; i < lisr_pkg::BUFFER_DEPTH_DEF + 2; i++)
      load_sample(pick_sample(), i == lisr_pkg::BUFFER_DEPTH_DEF + 1);
    repeat (run_length(lisr_pkg::BUFFER_DEPTH_DEF, 20'd524288) + 2) pull_once();
    settle();

    while (sent_items < N_ITEMS) begin
      idle_on = (sent_items < IDLE_STOP) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) write_speed(pick_speed());
      case ($urandom_range(0, 15))
        0: len = 1;
        1: len = $urandom_range(25, 64);
        default: len = $urandom_range(2, 24);
      endcase
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) pull_once();
        load_sample(pick_sample(), i == len - 1);
      end
      n = run_length(len, cur_speed);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
      else n += $urandom_range(1, 3);
      if (n > N_ITEMS - sent_items) n = N_ITEMS - sent_items;
      if (n < 0) n = 0;
      repeat (n) pull_once();
    end

    start <= 1'b0;
    w = 0;
    while (sb.pending.size() != 0 && w < 1000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors += sb.pending.size();
    end
    $display("run: %0d loads, %0d pulls (%0d samples out, %0d end-of-buffer answers)",
             sb.loads, sb.pulls, sb.outputs, sb.ends);
    $display("run: %0d speed writes incl. zero and 0xFFFFF, one full buffer with dropped loads",
             sb.speed_writes);
    if (sb.errors == 0) begin
      $display("linear_interp_speed_resampler_tb OK");
    end else begin
      $display("linear_interp_speed_resampler_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("linear_interp_speed_resampler_tb NOT OK");
    $finish;
  end

endmodule
